// File: hw/rtl/pwgi_pkg.sv
// ============================================================================
// pwgi_pkg - shared widths, register indexes and types
// Widths of the Q16.16 datapath of the PID controller and the register map
// of its configuration port.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package pwgi_pkg;

    localparam int ERR_W      = 32;  // error sample, signed Q16.16
    localparam int GAIN_W     = 32;  // gains, signed Q16.16
    localparam int RANGE_W    = 31;  // integral range, unsigned Q15.16
    localparam int LIMIT_W    = 47;  // integral clamp bound, unsigned Q31.16
    localparam int SUM_W      = 48;  // integral sum, signed Q32.16
    localparam int DRIVE_W    = 48;  // controller output, signed Q32.16
    localparam int DERIV_W    = ERR_W + 1;
    localparam int FRAC_W     = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = LIMIT_W;

    // The integral product is split at this bit of the sum.
    localparam int SPLIT_W    = 24;

    localparam int PE_W   = GAIN_W + ERR_W;                // 64
    localparam int PD_W   = GAIN_W + DERIV_W;              // 65
    localparam int PLO_W  = GAIN_W + SPLIT_W + 1;          // 57
    localparam int PHI_W  = GAIN_W + SUM_W - SPLIT_W;      // 56
    localparam int S1_W   = PD_W + 1;                      // 66
    localparam int S2_W   = PHI_W + SPLIT_W + 1;           // 81
    localparam int TOT_W  = S2_W + 1;                      // 82

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_RANGE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd4;

    // Load strobes of the two adder stages.
    typedef struct packed {
        logic ld_part;
        logic ld_out;
    } sum_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/pid_with_gated_integral.sv
// ============================================================================
// pid_with_gated_integral - PID controller with gated, clamped integral
// One signed Q16.16 error beat in, one result beat out: the saturated
// controller output, the integral sum after the step and a saturation flag.
//
// Channels: s_tdata carries the error sample; m_tdata carries the drive and
// the integral sum, m_tuser the saturation flag. Gains, integral range and
// integral limit are written through cfg_wen / cfg_index / cfg_data; the user
// must write them only while no beat is in flight; the block does not enforce it.
// Path: an accepted beat passes the input register, the state update, the
// multipliers and two adder steps before it is presented on m_tvalid.
// Throughput: one beat per cycle while m_tready stays high; every stage is a
// single register, and the integral update closes its loop through one register.
// Reset clears the gains, range, limit, integral sum and previous error and
// empties the pipeline. When the receiver stalls, results stay in the output
// register and each stage keeps taking beats until it holds one; s_tready
// drops only once the pipeline is full.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pid_with_gated_integral
    import pwgi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [ERR_W-1:0]        s_tdata,     // [31:0] error_in
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [DRIVE_W+SUM_W-1:0] m_tdata,    // [47:0] drive, [95:48] integral_sum
    output logic [0:0]              m_tuser,     // [0] drive_saturated
    input  logic                    cfg_wen,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    // Configuration registers.
    logic signed [GAIN_W-1:0] prop_gain_reg;
    logic signed [GAIN_W-1:0] integ_gain_reg;
    logic signed [GAIN_W-1:0] deriv_gain_reg;
    logic [RANGE_W-1:0]       range_reg;
    logic [LIMIT_W-1:0]       limit_reg;

    // Stage valid bits: input, state update, multiply, partial sum, output.
    logic v_in_reg, v_st_reg, v_mul_reg, v_part_reg, v_out_reg;
    logic rdy_in, rdy_st, rdy_mul, rdy_part, rdy_out;

    logic signed [ERR_W-1:0]   err_in_reg;

    logic signed [SUM_W-1:0]   st_acc;
    logic signed [ERR_W-1:0]   st_err;
    logic signed [DERIV_W-1:0] st_deriv;

    logic signed [PE_W-1:0]    pe;
    logic signed [PD_W-1:0]    pd;
    logic signed [PLO_W-1:0]   plo;
    logic signed [PHI_W-1:0]   phi;
    logic signed [SUM_W-1:0]   mul_acc;

    sum_ctl_t                  sum_ctl;
    logic [DRIVE_W-1:0]        drive;
    logic [SUM_W-1:0]          integral_sum;
    logic                      drive_saturated;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= '0;
            integ_gain_reg <= '0;
            deriv_gain_reg <= '0;
            range_reg      <= '0;
            limit_reg      <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_PROP_GAIN:      prop_gain_reg  <= cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN:     integ_gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN:     deriv_gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_INTEGRAL_RANGE: range_reg      <= cfg_data[RANGE_W-1:0];
                CFG_INTEGRAL_LIMIT: limit_reg      <= cfg_data[LIMIT_W-1:0];
                default:            ;
            endcase
        end
    end

    // A stage can take a beat when it is empty or its beat moves on this cycle.
    always_comb
    begin
        rdy_out  = !v_out_reg  || m_tready;
        rdy_part = !v_part_reg || rdy_out;
        rdy_mul  = !v_mul_reg  || rdy_part;
        rdy_st   = !v_st_reg   || rdy_mul;
        rdy_in   = !v_in_reg   || rdy_st;

        sum_ctl.ld_part = v_mul_reg  && rdy_part;
        sum_ctl.ld_out  = v_part_reg && rdy_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_in_reg   <= 1'b0;
            v_st_reg   <= 1'b0;
            v_mul_reg  <= 1'b0;
            v_part_reg <= 1'b0;
            v_out_reg  <= 1'b0;
        end
        else
        begin
            if (rdy_in)
            begin
                v_in_reg <= s_tvalid;
            end
            if (rdy_st)
            begin
                v_st_reg <= v_in_reg;
            end
            if (rdy_mul)
            begin
                v_mul_reg <= v_st_reg;
            end
            if (rdy_part)
            begin
                v_part_reg <= v_mul_reg;
            end
            if (rdy_out)
            begin
                v_out_reg <= v_part_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && rdy_in)
        begin
            err_in_reg <= s_tdata;
        end
    end

    pwgi_integ u_integ (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (v_in_reg && rdy_st),
        .err            (err_in_reg),
        .integ_en       (integ_gain_reg != '0),
        .integral_range (range_reg),
        .integral_limit (limit_reg),
        .acc            (st_acc),
        .err_out        (st_err),
        .deriv          (st_deriv)
    );

    pwgi_mult u_mult (
        .clk        (clk),
        .load       (v_st_reg && rdy_mul),
        .prop_gain  (prop_gain_reg),
        .integ_gain (integ_gain_reg),
        .deriv_gain (deriv_gain_reg),
        .err        (st_err),
        .deriv      (st_deriv),
        .acc        (st_acc),
        .pe         (pe),
        .pd         (pd),
        .plo        (plo),
        .phi        (phi),
        .acc_out    (mul_acc)
    );

    pwgi_sum u_sum (
        .clk             (clk),
        .ctl             (sum_ctl),
        .pe              (pe),
        .pd              (pd),
        .plo             (plo),
        .phi             (phi),
        .acc             (mul_acc),
        .drive           (drive),
        .integral_sum    (integral_sum),
        .drive_saturated (drive_saturated)
    );

    assign s_tready = rdy_in;
    assign m_tvalid = v_out_reg;
    assign m_tdata  = {integral_sum, drive};
    assign m_tuser  = drive_saturated;

endmodule

`default_nettype wire

// File: hw/rtl/pwgi_integ.sv
// ============================================================================
// pwgi_integ - integral and derivative update stage
// Holds the controller state (integral sum and previous error). On each beat
// it gates, accumulates and clamps the integral and forms the error difference.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pwgi_integ
    import pwgi_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic signed [ERR_W-1:0]    err,
    input  logic                       integ_en,
    input  logic        [RANGE_W-1:0]  integral_range,
    input  logic        [LIMIT_W-1:0]  integral_limit,
    output logic signed [SUM_W-1:0]    acc,
    output logic signed [ERR_W-1:0]    err_out,
    output logic signed [DERIV_W-1:0]  deriv
);

    logic signed [SUM_W-1:0]   acc_reg,   acc_next;
    logic signed [ERR_W-1:0]   prev_reg;
    logic signed [DERIV_W-1:0] deriv_reg, deriv_next;

    logic signed [DERIV_W-1:0] err_ext;
    logic signed [DERIV_W-1:0] mag_ext;
    logic                      in_range;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W:0]     lim_pos;
    logic signed [SUM_W:0]     lim_neg;
    logic signed [SUM_W:0]     clamped;

    always_comb
    begin
        err_ext  = {err[ERR_W-1], err};
        // The most negative error has magnitude 2^31, which never falls below the range.
        mag_ext  = err[ERR_W-1] ? -err_ext : err_ext;
        in_range = (err != '0) &&
                   (mag_ext[ERR_W-1:0] < {{(ERR_W-RANGE_W){1'b0}}, integral_range});

        sum_wide = {acc_reg[SUM_W-1], acc_reg} +
                   {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err};
        lim_pos  = {{(SUM_W+1-LIMIT_W){1'b0}}, integral_limit};
        lim_neg  = -lim_pos;

        if (sum_wide > lim_pos)
        begin
            clamped = lim_pos;
        end
        else if (sum_wide < lim_neg)
        begin
            clamped = lim_neg;
        end
        else
        begin
            clamped = sum_wide;
        end

        if (!integ_en)
        begin
            acc_next = acc_reg;
        end
        else if (in_range)
        begin
            acc_next = clamped[SUM_W-1:0];
        end
        else
        begin
            acc_next = '0;
        end

        deriv_next = err_ext - {prev_reg[ERR_W-1], prev_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            prev_reg <= '0;
        end
        else if (load)
        begin
            acc_reg  <= acc_next;
            prev_reg <= err;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            deriv_reg <= deriv_next;
        end
    end

    // The state registers double as this stage's output registers.
    assign acc     = acc_reg;
    assign err_out = prev_reg;
    assign deriv   = deriv_reg;

endmodule

`default_nettype wire

// File: hw/rtl/pwgi_mult.sv
// ============================================================================
// pwgi_mult - gain multiplier stage
// Forms the proportional and derivative products and the integral product
// as two partial products, each registered.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pwgi_mult
    import pwgi_pkg::*;
(
    input  logic                       clk,
    input  logic                       load,
    input  logic signed [GAIN_W-1:0]   prop_gain,
    input  logic signed [GAIN_W-1:0]   integ_gain,
    input  logic signed [GAIN_W-1:0]   deriv_gain,
    input  logic signed [ERR_W-1:0]    err,
    input  logic signed [DERIV_W-1:0]  deriv,
    input  logic signed [SUM_W-1:0]    acc,
    output logic signed [PE_W-1:0]     pe,
    output logic signed [PD_W-1:0]     pd,
    output logic signed [PLO_W-1:0]    plo,
    output logic signed [PHI_W-1:0]    phi,
    output logic signed [SUM_W-1:0]    acc_out
);

    logic signed [PE_W-1:0]  pe_reg,  pe_next;
    logic signed [PD_W-1:0]  pd_reg,  pd_next;
    logic signed [PLO_W-1:0] plo_reg, plo_next;
    logic signed [PHI_W-1:0] phi_reg, phi_next;
    logic signed [SUM_W-1:0] acc_reg;

    always_comb
    begin
        pe_next  = prop_gain * err;
        pd_next  = deriv_gain * deriv;
        // Low half of the sum is unsigned, the high half carries the sign.
        plo_next = integ_gain * $signed({1'b0, acc[SPLIT_W-1:0]});
        phi_next = integ_gain * $signed(acc[SUM_W-1:SPLIT_W]);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pe_reg  <= pe_next;
            pd_reg  <= pd_next;
            plo_reg <= plo_next;
            phi_reg <= phi_next;
            acc_reg <= acc;
        end
    end

    assign pe      = pe_reg;
    assign pd      = pd_reg;
    assign plo     = plo_reg;
    assign phi     = phi_reg;
    assign acc_out = acc_reg;

endmodule

`default_nettype wire

// File: hw/rtl/pwgi_sum.sv
// ============================================================================
// pwgi_sum - product adder, rounding and saturation
// Adds the products in two registered steps, rounds the Q50.32 total to
// Q32.16 and saturates it to the 48-bit output range.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pwgi_sum
    import pwgi_pkg::*;
(
    input  logic                       clk,
    input  sum_ctl_t                   ctl,
    input  logic signed [PE_W-1:0]     pe,
    input  logic signed [PD_W-1:0]     pd,
    input  logic signed [PLO_W-1:0]    plo,
    input  logic signed [PHI_W-1:0]    phi,
    input  logic signed [SUM_W-1:0]    acc,
    output logic        [DRIVE_W-1:0]  drive,
    output logic        [SUM_W-1:0]    integral_sum,
    output logic                       drive_saturated
);

    localparam logic [TOT_W-1:0] ROUND_HALF = TOT_W'(1) << (FRAC_W - 1);
    localparam logic [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
    localparam logic [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};
    localparam int TOP_LO = FRAC_W + DRIVE_W - 1;

    logic [S1_W-1:0]    s1_reg,  s1_next;
    logic [S2_W-1:0]    s2_reg,  s2_next;
    logic [SUM_W-1:0]   acc_part_reg;

    logic [DRIVE_W-1:0] drive_reg, drive_next;
    logic               sat_reg,   sat_next;
    logic [SUM_W-1:0]   acc_out_reg;

    logic [TOT_W-1:0]   total;
    logic               fits;

    always_comb
    begin
        s1_next = {{(S1_W-PE_W){pe[PE_W-1]}}, pe} + {{(S1_W-PD_W){pd[PD_W-1]}}, pd};
        s2_next = {phi[PHI_W-1], phi, {SPLIT_W{1'b0}}} +
                  {{(S2_W-PLO_W){plo[PLO_W-1]}}, plo};

        total = {{(TOT_W-S1_W){s1_reg[S1_W-1]}}, s1_reg} +
                {s2_reg[S2_W-1], s2_reg} + ROUND_HALF;

        // The rounded value fits when all bits above the output's sign bit agree with it.
        fits = (&total[TOT_W-1:TOP_LO]) || (~|total[TOT_W-1:TOP_LO]);

        if (fits)
        begin
            drive_next = total[TOP_LO:FRAC_W];
            sat_next   = 1'b0;
        end
        else
        begin
            drive_next = total[TOT_W-1] ? DRIVE_MIN : DRIVE_MAX;
            sat_next   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_part)
        begin
            s1_reg       <= s1_next;
            s2_reg       <= s2_next;
            acc_part_reg <= acc;
        end
        if (ctl.ld_out)
        begin
            drive_reg   <= drive_next;
            sat_reg     <= sat_next;
            acc_out_reg <= acc_part_reg;
        end
    end

    assign drive           = drive_reg;
    assign drive_saturated = sat_reg;
    assign integral_sum    = acc_out_reg;

endmodule

`default_nettype wire
